// ----- sv/thos_pkg.sv -----
// shared types, constants and microcode table of the tagged heap operand stack
package thos_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 1024;
  localparam int unsigned HEAP_BLOCKS_DEF = 4096;

  localparam int unsigned CMD_W  = 3;
  localparam int unsigned OFF_W  = 11;
  localparam int unsigned SIZE_W = 16;
  localparam int unsigned TYPE_W = 6;
  localparam int unsigned REF_W  = 12;
  localparam int unsigned ERR_W  = 3;
  localparam int unsigned TAG_W  = 8;

  localparam int unsigned BLOCK_SHIFT  = 3;
  localparam int unsigned BLOCK_MASK   = (1 << BLOCK_SHIFT) - 1;
  localparam int unsigned NBLK_W       = SIZE_W + 1 - BLOCK_SHIFT;
  localparam int unsigned TAG_PTR_BIT  = 6;
  localparam int unsigned TAG_CONT_BIT = 7;

  localparam int unsigned UPC_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_DUP   = 3'd0,
    CMD_STORE = 3'd1,
    CMD_POP   = 3'd2,
    CMD_SWAP  = 3'd3,
    CMD_TYPE  = 3'd4,
    CMD_DATA  = 3'd5,
    CMD_ALLOC = 3'd6
  } cmd_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK       = 3'd0,
    ERR_OFFSET   = 3'd1,
    ERR_REF      = 3'd2,
    ERR_OVERFLOW = 3'd3,
    ERR_HEAP     = 3'd4
  } err_e;

  typedef enum logic [UPC_W-1:0] {
    U_IDLE,
    U_ERR_EARLY,
    U_ERR_REF,
    U_DUP_RD,
    U_DUP_PUSH,
    U_STO_RD,
    U_STO_WR,
    U_POP,
    U_SWP_RD_S,
    U_SWP_RD_T,
    U_SWP_WR_S,
    U_SWP_WR_T,
    U_TYP_RD,
    U_TYP_TAG,
    U_TYP_CHK,
    U_TYP_OUT,
    U_DAT_RD,
    U_DAT_TAG,
    U_DAT_CHK,
    U_DAT_OUT,
    U_ALC_HDR,
    U_ALC_CONT,
    U_ALC_PUSH
  } upc_e;

  typedef enum logic [1:0] {
    AS_SLOT,
    AS_TOP,
    AS_PUSH
  } addr_sel_e;

  typedef enum logic [1:0] {
    WD_RDATA,
    WD_A,
    WD_CUR
  } wdata_sel_e;

  typedef enum logic [1:0] {
    SP_HOLD,
    SP_INC,
    SP_DEC,
    SP_SLOT
  } sp_op_e;

  typedef enum logic [1:0] {
    RS_ZERO,
    RS_RDATA,
    RS_A,
    RS_CUR
  } ref_sel_e;

  typedef enum logic [1:0] {
    ES_OK,
    ES_LATCHED,
    ES_REF
  } err_sel_e;

  typedef enum logic [2:0] {
    C_NONE,
    C_ALWAYS,
    C_ACCEPT,
    C_REF_BAD,
    C_REM_ZERO
  } cond_e;

  typedef struct packed {
    logic       rdy;
    logic       stk_re;
    addr_sel_e  stk_ra;
    logic       stk_we;
    addr_sel_e  stk_wa;
    wdata_sel_e stk_wd;
    logic       lat_a;
    logic       tag_re;
    logic       tag_we;
    logic       tag_cont;
    sp_op_e     sp_op;
    logic       cur_upd;
    logic       emit;
    ref_sel_e   ref_sel;
    logic       type_tag;
    err_sel_e   err_sel;
    cond_e      cond;
    logic       stay;
    upc_e       target;
  } ucw_t;

  typedef struct packed {
    ucw_t cw;
    logic go;
  } ctrl_t;

  typedef struct packed {
    logic early_err;
    logic ref_bad;
    logic rem_zero;
    logic out_busy;
  } stat_t;

  // a taken test jump squashes the side effects of its step
  function automatic ucw_t ucode(upc_e a);
    ucw_t w;
    w = '0;
    w.target = U_IDLE;
    unique case (a)
      U_IDLE: begin
        w.rdy  = 1'b1;
        w.cond = C_ACCEPT;
        w.stay = 1'b1;
      end
      U_ERR_EARLY: begin
        w.emit    = 1'b1;
        w.err_sel = ES_LATCHED;
        w.cond    = C_ALWAYS;
      end
      U_ERR_REF: begin
        w.emit    = 1'b1;
        w.err_sel = ES_REF;
        w.cond    = C_ALWAYS;
      end
      U_DUP_RD: begin
        w.stk_re = 1'b1;
        w.stk_ra = AS_SLOT;
      end
      U_DUP_PUSH: begin
        w.stk_we  = 1'b1;
        w.stk_wa  = AS_PUSH;
        w.stk_wd  = WD_RDATA;
        w.sp_op   = SP_INC;
        w.emit    = 1'b1;
        w.ref_sel = RS_RDATA;
        w.cond    = C_ALWAYS;
      end
      U_STO_RD: begin
        w.stk_re = 1'b1;
        w.stk_ra = AS_TOP;
      end
      U_STO_WR: begin
        w.stk_we  = 1'b1;
        w.stk_wa  = AS_SLOT;
        w.stk_wd  = WD_RDATA;
        w.sp_op   = SP_DEC;
        w.emit    = 1'b1;
        w.ref_sel = RS_RDATA;
        w.cond    = C_ALWAYS;
      end
      U_POP: begin
        w.sp_op = SP_SLOT;
        w.emit  = 1'b1;
        w.cond  = C_ALWAYS;
      end
      U_SWP_RD_S: begin
        w.stk_re = 1'b1;
        w.stk_ra = AS_SLOT;
      end
      U_SWP_RD_T: begin
        w.stk_re = 1'b1;
        w.stk_ra = AS_TOP;
        w.lat_a  = 1'b1;
      end
      U_SWP_WR_S: begin
        w.stk_we = 1'b1;
        w.stk_wa = AS_SLOT;
        w.stk_wd = WD_RDATA;
      end
      U_SWP_WR_T: begin
        w.stk_we  = 1'b1;
        w.stk_wa  = AS_TOP;
        w.stk_wd  = WD_A;
        w.emit    = 1'b1;
        w.ref_sel = RS_A;
        w.cond    = C_ALWAYS;
      end
      U_TYP_RD, U_DAT_RD: begin
        w.stk_re = 1'b1;
        w.stk_ra = AS_SLOT;
      end
      U_TYP_TAG, U_DAT_TAG: begin
        w.lat_a  = 1'b1;
        w.tag_re = 1'b1;
      end
      U_TYP_CHK, U_DAT_CHK: begin
        w.cond   = C_REF_BAD;
        w.target = U_ERR_REF;
      end
      U_TYP_OUT: begin
        w.emit     = 1'b1;
        w.ref_sel  = RS_A;
        w.type_tag = 1'b1;
        w.cond     = C_ALWAYS;
      end
      U_DAT_OUT: begin
        w.emit    = 1'b1;
        w.ref_sel = RS_A;
        w.cond    = C_ALWAYS;
      end
      U_ALC_HDR: begin
        w.tag_we = 1'b1;
      end
      U_ALC_CONT: begin
        w.tag_we   = 1'b1;
        w.tag_cont = 1'b1;
        w.cond     = C_REM_ZERO;
        w.stay     = 1'b1;
        w.target   = U_ALC_PUSH;
      end
      U_ALC_PUSH: begin
        w.stk_we  = 1'b1;
        w.stk_wa  = AS_PUSH;
        w.stk_wd  = WD_CUR;
        w.sp_op   = SP_INC;
        w.cur_upd = 1'b1;
        w.emit    = 1'b1;
        w.ref_sel = RS_CUR;
        w.cond    = C_ALWAYS;
      end
      default: begin
        w.cond = C_ALWAYS;
      end
    endcase
    return w;
  endfunction

  function automatic upc_e entry_of(cmd_e c);
    upc_e u;
    unique case (c)
      CMD_DUP:   u = U_DUP_RD;
      CMD_STORE: u = U_STO_RD;
      CMD_POP:   u = U_POP;
      CMD_SWAP:  u = U_SWP_RD_S;
      CMD_TYPE:  u = U_TYP_RD;
      CMD_DATA:  u = U_DAT_RD;
      CMD_ALLOC: u = U_ALC_HDR;
      default:   u = U_ERR_EARLY;
    endcase
    return u;
  endfunction

endpackage

// ----- sv/thos_ram.sv -----
// generic single write port ram with registered read
module thos_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/thos_seq.sv -----
// microcode sequencer: step counter, control rom and jump logic
module thos_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [thos_pkg::CMD_W-1:0]  command_i,
  input  thos_pkg::stat_t             stat_i,
  output thos_pkg::ctrl_t             ctrl_o
);
  import thos_pkg::*;

  upc_e upc_q, upc_d;
  ucw_t cw;
  logic taken;
  logic stall;

  assign cw = ucode(upc_q);

  always_comb begin
    unique case (cw.cond)
      C_NONE:     taken = 1'b0;
      C_ALWAYS:   taken = 1'b1;
      C_ACCEPT:   taken = in_valid_i && cw.rdy;
      C_REF_BAD:  taken = stat_i.ref_bad;
      C_REM_ZERO: taken = stat_i.rem_zero;
      default:    taken = 1'b0;
    endcase
  end

  assign stall = cw.emit && stat_i.out_busy;

  always_comb begin
    priority if (stall) begin
      upc_d = upc_q;
    end else if (taken && cw.cond == C_ACCEPT) begin
      upc_d = stat_i.early_err ? U_ERR_EARLY : entry_of(cmd_e'(command_i));
    end else if (taken) begin
      upc_d = cw.target;
    end else if (cw.stay) begin
      upc_d = upc_q;
    end else begin
      upc_d = upc_e'(upc_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= U_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign ctrl_o.cw = cw;
  assign ctrl_o.go = !stall && !(taken && cw.cond != C_ALWAYS);

endmodule

// ----- sv/thos_dp.sv -----
// datapath: stack and tag memories, pointers, checks and output register
module thos_dp #(
  parameter int unsigned STACK_DEPTH = thos_pkg::STACK_DEPTH_DEF,
  parameter int unsigned HEAP_BLOCKS = thos_pkg::HEAP_BLOCKS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic [thos_pkg::CMD_W-1:0]        command_i,
  input  logic signed [thos_pkg::OFF_W-1:0] offset_i,
  input  logic [thos_pkg::SIZE_W-1:0]       size_bytes_i,
  input  logic [thos_pkg::TYPE_W-1:0]       object_type_i,
  input  logic                              holds_pointers_i,
  input  logic                              out_ready_i,
  input  thos_pkg::ctrl_t                   ctrl_i,
  output thos_pkg::stat_t                   stat_o,
  output logic                              out_valid_o,
  output logic [thos_pkg::REF_W-1:0]        reference_o,
  output logic [thos_pkg::TYPE_W-1:0]       type_out_o,
  output logic [thos_pkg::ERR_W-1:0]        error_o
);
  import thos_pkg::*;

  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW  = $clog2(STACK_DEPTH);
  localparam int unsigned HW  = $clog2(HEAP_BLOCKS);
  localparam int unsigned CW  = $clog2(HEAP_BLOCKS + 1);
  localparam int unsigned SW  = ((SPW > OFF_W) ? SPW : OFF_W) + 1;
  localparam int unsigned HCW = ((CW > NBLK_W) ? CW : NBLK_W) + 1;

  ucw_t cw;
  logic go;
  logic accept;

  logic [SPW-1:0] sp_q;
  logic [CW-1:0]  cur_q;
  logic [AW-1:0]  slot_q;
  err_e           err_q;
  logic [TAG_W-2:0] tag_q;
  logic [HW-1:0]  a_q;
  logic [CW-1:0]  blk_q;
  logic [NBLK_W-1:0] rem_q;

  logic              out_valid_q;
  logic [REF_W-1:0]  ref_q;
  logic [TYPE_W-1:0] type_q;
  err_e              out_err_q;

  logic signed [SW-1:0] sp_s, off_s, slot_s;
  logic                 slot_ok;
  logic                 stack_full;
  logic [SIZE_W:0]      size_rnd;
  logic [NBLK_W-1:0]    nb_raw, nb;
  logic [HCW-1:0]       heap_room;
  logic                 heap_full;
  err_e                 early_code;
  logic                 early_flag;

  logic          stk_we, stk_re;
  logic [AW-1:0] stk_waddr, stk_raddr, top_addr, push_addr;
  logic [HW-1:0] stk_wdata, stk_rdata;
  logic          tag_we, tag_re;
  logic [TAG_W-1:0] tag_wdata, tag_rdata;

  logic [REF_W-1:0]  ref_d;
  logic [TYPE_W-1:0] type_d;
  err_e              err_d;

  assign cw     = ctrl_i.cw;
  assign go     = ctrl_i.go;
  assign accept = in_valid_i && cw.rdy;

  // slot and early checks on the incoming transaction
  always_comb begin
    sp_s       = SW'(sp_q);
    off_s      = SW'(offset_i);
    slot_s     = offset_i[OFF_W-1] ? sp_s + off_s : off_s;
    slot_ok    = !slot_s[SW-1] && (slot_s < sp_s);
    stack_full = (sp_q == SPW'(STACK_DEPTH));
    size_rnd   = (SIZE_W + 1)'(size_bytes_i) + (SIZE_W + 1)'(BLOCK_MASK);
    nb_raw     = size_rnd[SIZE_W:BLOCK_SHIFT];
    nb         = (nb_raw == '0) ? NBLK_W'(1) : nb_raw;
    heap_room  = HCW'(HEAP_BLOCKS) - HCW'(cur_q);
    heap_full  = HCW'(nb) > heap_room;
  end

  always_comb begin
    early_code = ERR_OK;
    early_flag = 1'b0;
    unique case (cmd_e'(command_i))
      CMD_DUP: begin
        if (!slot_ok) begin
          early_code = ERR_OFFSET;
        end else if (stack_full) begin
          early_code = ERR_OVERFLOW;
        end
      end
      CMD_STORE, CMD_POP, CMD_SWAP, CMD_TYPE, CMD_DATA: begin
        if (!slot_ok) begin
          early_code = ERR_OFFSET;
        end
      end
      CMD_ALLOC: begin
        if (stack_full) begin
          early_code = ERR_OVERFLOW;
        end else if (heap_full) begin
          early_code = ERR_HEAP;
        end
      end
      default: begin
        early_flag = 1'b1;
      end
    endcase
    if (early_code != ERR_OK) begin
      early_flag = 1'b1;
    end
  end

  // stack memory ports
  assign top_addr  = AW'(sp_q - 1'b1);
  assign push_addr = AW'(sp_q);

  always_comb begin
    unique case (cw.stk_ra)
      AS_SLOT: stk_raddr = slot_q;
      AS_TOP:  stk_raddr = top_addr;
      AS_PUSH: stk_raddr = push_addr;
      default: stk_raddr = slot_q;
    endcase
    unique case (cw.stk_wa)
      AS_SLOT: stk_waddr = slot_q;
      AS_TOP:  stk_waddr = top_addr;
      AS_PUSH: stk_waddr = push_addr;
      default: stk_waddr = slot_q;
    endcase
    unique case (cw.stk_wd)
      WD_RDATA: stk_wdata = stk_rdata;
      WD_A:     stk_wdata = a_q;
      WD_CUR:   stk_wdata = HW'(cur_q);
      default:  stk_wdata = stk_rdata;
    endcase
  end

  assign stk_we = go && cw.stk_we;
  assign stk_re = go && cw.stk_re;

  thos_ram #(
    .WIDTH(HW),
    .DEPTH(STACK_DEPTH)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (stk_we),
    .waddr_i(stk_waddr),
    .wdata_i(stk_wdata),
    .re_i   (stk_re),
    .raddr_i(stk_raddr),
    .rdata_o(stk_rdata)
  );

  // tag memory ports
  assign tag_we    = go && cw.tag_we;
  assign tag_re    = go && cw.tag_re;
  assign tag_wdata = {cw.tag_cont, tag_q};

  thos_ram #(
    .WIDTH(TAG_W),
    .DEPTH(HEAP_BLOCKS)
  ) u_tag_ram (
    .clk_i  (clk_i),
    .we_i   (tag_we),
    .waddr_i(HW'(blk_q)),
    .wdata_i(tag_wdata),
    .re_i   (tag_re),
    .raddr_i(stk_rdata),
    .rdata_o(tag_rdata)
  );

  // result selection
  always_comb begin
    unique case (cw.ref_sel)
      RS_ZERO:  ref_d = '0;
      RS_RDATA: ref_d = REF_W'(stk_rdata);
      RS_A:     ref_d = REF_W'(a_q);
      RS_CUR:   ref_d = REF_W'(cur_q);
      default:  ref_d = '0;
    endcase
    type_d = cw.type_tag ? tag_rdata[TYPE_W-1:0] : '0;
    unique case (cw.err_sel)
      ES_OK:      err_d = ERR_OK;
      ES_LATCHED: err_d = err_q;
      ES_REF:     err_d = ERR_REF;
      default:    err_d = ERR_OK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q        <= '0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (go) begin
        unique case (cw.sp_op)
          SP_HOLD: sp_q <= sp_q;
          SP_INC:  sp_q <= sp_q + 1'b1;
          SP_DEC:  sp_q <= sp_q - 1'b1;
          SP_SLOT: sp_q <= SPW'(slot_q);
          default: sp_q <= sp_q;
        endcase
        if (cw.cur_upd) begin
          cur_q <= blk_q;
        end
      end
      if (go && cw.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      slot_q <= AW'(slot_s);
      err_q  <= early_code;
      tag_q  <= {holds_pointers_i, object_type_i};
      blk_q  <= cur_q;
      rem_q  <= nb - 1'b1;
    end else if (go && cw.tag_we) begin
      blk_q <= blk_q + 1'b1;
      if (cw.tag_cont) begin
        rem_q <= rem_q - 1'b1;
      end
    end
    if (go && cw.lat_a) begin
      a_q <= stk_rdata;
    end
    if (go && cw.emit) begin
      ref_q     <= ref_d;
      type_q    <= type_d;
      out_err_q <= err_d;
    end
  end

  assign stat_o.early_err = early_flag;
  assign stat_o.ref_bad   = !(CW'(a_q) < cur_q) || tag_rdata[TAG_CONT_BIT];
  assign stat_o.rem_zero  = (rem_q == '0);
  assign stat_o.out_busy  = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign reference_o = ref_q;
  assign type_out_o  = type_q;
  assign error_o     = out_err_q;

endmodule

// ----- sv/tagged_heap_operand_stack_unit.sv -----
// top level of the tagged heap operand stack with bump allocator
//
// channel  direction  handshake               payload
// in       input      in_valid_i / in_ready_o  command, offset, size_bytes, object_type,
//                                              holds_pointers
// out      output     out_valid_o / out_ready_i reference, type_out, error
//
// one transaction at a time: a new one is accepted only once the microcode program
// of the last one has ended; allocate writes a tag for each 8-byte block; the steps
// of each program are set by the single stack ram port pair and one tag write per
// cycle in the microcode program
// reset clears stack pointer and heap cursor at once, no clearing pass
// a waiting result stalls the sequencer only at its next result step
module tagged_heap_operand_stack_unit #(
  parameter int unsigned STACK_DEPTH = thos_pkg::STACK_DEPTH_DEF,
  parameter int unsigned HEAP_BLOCKS = thos_pkg::HEAP_BLOCKS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [thos_pkg::CMD_W-1:0]        command_i,
  input  logic signed [thos_pkg::OFF_W-1:0] offset_i,
  input  logic [thos_pkg::SIZE_W-1:0]       size_bytes_i,
  input  logic [thos_pkg::TYPE_W-1:0]       object_type_i,
  input  logic                              holds_pointers_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [thos_pkg::REF_W-1:0]        reference_o,
  output logic [thos_pkg::TYPE_W-1:0]       type_out_o,
  output logic [thos_pkg::ERR_W-1:0]        error_o
);
  import thos_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  thos_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .command_i (command_i),
    .stat_i    (stat),
    .ctrl_o    (ctrl)
  );

  thos_dp #(
    .STACK_DEPTH(STACK_DEPTH),
    .HEAP_BLOCKS(HEAP_BLOCKS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .command_i       (command_i),
    .offset_i        (offset_i),
    .size_bytes_i    (size_bytes_i),
    .object_type_i   (object_type_i),
    .holds_pointers_i(holds_pointers_i),
    .out_ready_i     (out_ready_i),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .out_valid_o     (out_valid_o),
    .reference_o     (reference_o),
    .type_out_o      (type_out_o),
    .error_o         (error_o)
  );

  assign in_ready_o = ctrl.cw.rdy;

endmodule

// ----- sv/thos_checker.sv -----
// port level assertions for the tagged heap operand stack, bound to the top level
module thos_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic [thos_pkg::CMD_W-1:0]        command_i,
  input logic signed [thos_pkg::OFF_W-1:0] offset_i,
  input logic [thos_pkg::SIZE_W-1:0]       size_bytes_i,
  input logic [thos_pkg::TYPE_W-1:0]       object_type_i,
  input logic                              holds_pointers_i,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [thos_pkg::REF_W-1:0]        reference_o,
  input logic [thos_pkg::TYPE_W-1:0]       type_out_o,
  input logic [thos_pkg::ERR_W-1:0]        error_o
);
  import thos_pkg::*;

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(command_i) && $stable(offset_i) &&
      $stable(size_bytes_i) && $stable(object_type_i) && $stable(holds_pointers_i))
    else $error("input transaction changed while waiting");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(reference_o) &&
      $stable(type_out_o) && $stable(error_o))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o != ERR_OK |-> reference_o == '0 && type_out_o == '0)
    else $error("error result carries nonzero payload");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> error_o == ERR_OK || error_o == ERR_OFFSET || error_o == ERR_REF ||
      error_o == ERR_OVERFLOW || error_o == ERR_HEAP)
    else $error("undefined error code");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while previous transaction in progress");

endmodule

bind tagged_heap_operand_stack_unit thos_checker u_thos_checker (.*);
